[sv/geo_mask_pixel_tint_macros.svh]
// ---------------------------------------------------------------------------
// geo_mask_pixel_tint assertion macros
// concurrent checks that vanish when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef GEO_MASK_PIXEL_TINT_MACROS_SVH
`define GEO_MASK_PIXEL_TINT_MACROS_SVH

`ifndef SYNTH
`define GMPT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gmpt assertion failed");
`define GMPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gmpt assertion failed");
`else
`define GMPT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define GMPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/gmpt_pkg.sv]
// ---------------------------------------------------------------------------
// gmpt_pkg
// shared widths, codes and configuration types of the mask tint block
// ---------------------------------------------------------------------------
package gmpt_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int IDX_W            = 12;
  localparam int RGB_W            = 8;
  localparam int RAW_W            = 8;
  localparam int SIZE_W           = 10;
  localparam int ORIGIN_W         = 36;
  localparam int STEP_W           = 32;
  localparam int MASK_COLUMNS_MAX = 512;
  localparam int MASK_ROWS_MAX    = 512;
  localparam int STORE_DEPTH      = 262144;
  localparam int ADDR_W           = $clog2(STORE_DEPTH);
  localparam int CODE_W           = 2;
  localparam int MX_W             = $clog2(MASK_COLUMNS_MAX);
  localparam int MY_W             = $clog2(MASK_ROWS_MAX);
  localparam int PROD_W           = IDX_W + STEP_W;
  localparam int COORD_W          = PROD_W + 2;
  localparam int IP_W             = COORD_W - FRAC_BITS;
  localparam int LIN_W            = MY_W + SIZE_W;
  localparam int SUM_W            = RGB_W + 2;
  localparam int TINT_RECIP       = 173019;
  localparam int TINT_RECIP_W     = 18;
  localparam int TINT_SHIFT       = 19;
  localparam int TINT_PROD_W      = SUM_W + TINT_RECIP_W;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 36;
  localparam int IN_TDATA_W       = 80;
  localparam int OUT_TDATA_W      = 24;

  localparam logic [RAW_W-1:0]  RAW_NONE  = 8'd0;
  localparam logic [RAW_W-1:0]  RAW_BLUE  = 8'd2;
  localparam logic [RGB_W-1:0]  FULL_BYTE = 8'hff;

  typedef enum logic {
    MODE_LOAD,
    MODE_PIXEL
  } mode_t;

  typedef enum logic [CODE_W-1:0] {
    CODE_NONE,
    CODE_TINT,
    CODE_BLUE
  } mask_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASK_ACTIVE,
    REG_MASK_COLUMNS,
    REG_MASK_ROWS,
    REG_COLUMN_ORIGIN,
    REG_COLUMN_STEP,
    REG_ROW_ORIGIN,
    REG_ROW_STEP
  } cfg_reg_t;

  typedef struct packed {
    logic                active;
    logic [SIZE_W-1:0]   cols;
    logic [SIZE_W-1:0]   rows;
    logic [ORIGIN_W-1:0] col_origin;
    logic [STEP_W-1:0]   col_step;
    logic [ORIGIN_W-1:0] row_origin;
    logic [STEP_W-1:0]   row_step;
  } cfg_t;

  function automatic mask_code_t encode_code(input logic [RAW_W-1:0] raw);
    mask_code_t c;
    case (raw)
      RAW_NONE: c = CODE_NONE;
      RAW_BLUE: c = CODE_BLUE;
      default:  c = CODE_TINT;
    endcase
    return c;
  endfunction

endpackage

[sv/gmpt_cfg_regs.sv]
// ---------------------------------------------------------------------------
// gmpt_cfg_regs
// configuration register file, mask sizes saturated on write
// ---------------------------------------------------------------------------
module gmpt_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gmpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gmpt_pkg::CFG_DATA_W-1:0]   cfg_data,
  output gmpt_pkg::cfg_t                    cfg
);
  import gmpt_pkg::*;

  cfg_t              cfg_r;
  logic [SIZE_W-1:0] size_wr;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;
  assign size_wr   = cfg_data[SIZE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active     <= 1'b0;
      cfg_r.cols       <= SIZE_W'(MASK_COLUMNS_MAX);
      cfg_r.rows       <= SIZE_W'(MASK_ROWS_MAX);
      cfg_r.col_origin <= '0;
      cfg_r.col_step   <= STEP_W'(1 << FRAC_BITS);
      cfg_r.row_origin <= '0;
      cfg_r.row_step   <= STEP_W'(1 << FRAC_BITS);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MASK_ACTIVE:   cfg_r.active <= cfg_data[0];
        REG_MASK_COLUMNS: begin
          cfg_r.cols <= (size_wr > SIZE_W'(MASK_COLUMNS_MAX)) ?
                        SIZE_W'(MASK_COLUMNS_MAX) : size_wr;
        end
        REG_MASK_ROWS: begin
          cfg_r.rows <= (size_wr > SIZE_W'(MASK_ROWS_MAX)) ?
                        SIZE_W'(MASK_ROWS_MAX) : size_wr;
        end
        REG_COLUMN_ORIGIN: cfg_r.col_origin <= cfg_data[ORIGIN_W-1:0];
        REG_COLUMN_STEP:   cfg_r.col_step   <= cfg_data[STEP_W-1:0];
        REG_ROW_ORIGIN:    cfg_r.row_origin <= cfg_data[ORIGIN_W-1:0];
        REG_ROW_STEP:      cfg_r.row_step   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[sv/gmpt_mask_ram.sv]
// ---------------------------------------------------------------------------
// gmpt_mask_ram
// single port mask store, one access per cycle, registered read data
// ---------------------------------------------------------------------------
module gmpt_mask_ram (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          we,
  input  logic [gmpt_pkg::ADDR_W-1:0]   addr,
  input  logic [gmpt_pkg::CODE_W-1:0]   wdata,
  output logic [gmpt_pkg::CODE_W-1:0]   rdata
);
  import gmpt_pkg::*;

  logic [CODE_W-1:0] mask_mem [STORE_DEPTH];
  logic [CODE_W-1:0] rd_data_r;

  assign rdata = rd_data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mask_mem[addr] <= wdata;
      end else begin
        rd_data_r <= mask_mem[addr];
      end
    end
  end

endmodule

[sv/geo_mask_pixel_tint.sv]
// ---------------------------------------------------------------------------
// geo_mask_pixel_tint
// mask store loader and nearest neighbour mask tint for rgb pixels
// ---------------------------------------------------------------------------
// in_* carries one beat per item: in_tuser selects a mask load (0) or a pixel
// (1). a load writes one 2-bit code into the 256k-entry mask store and gives
// no output beat. a pixel is mapped to mask coordinates (origin + index * step,
// Q.16), looked up and tinted, and gives exactly one out_* beat with the color
// in out_tdata and the applied code in out_tuser.
// throughput is one beat per cycle while out_tready is high: a six-register
// pipeline (input, products, range check, address, mask read, output) with
// one memory access per beat.
// loads and pixels reach the memory in arrival order, so a pixel always sees
// every load accepted before it.
// cfg_* writes registers 0..6 and is always ready; write only while idle.
// reset restores register defaults and empties the pipeline; the mask store
// is not cleared and holds no valid contents until loaded.
// when out_tready is low the pipeline fills its empty stages and keeps
// accepting until the bubbles are gone, then in_tready drops.
// ---------------------------------------------------------------------------
`include "geo_mask_pixel_tint_macros.svh"

module geo_mask_pixel_tint (
  input  logic                                clk,
  input  logic                                rst_n,
  // input beat
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // column[11:0] row[23:12] red_in[31:24] green_in[39:32] blue_in[47:40]
  // mask_address[65:48] mask_value[73:66] zero[79:74]
  input  logic [gmpt_pkg::IN_TDATA_W-1:0]     in_tdata,
  // mode[0]
  input  logic                                in_tuser,
  // result beat
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // red_out[7:0] green_out[15:8] blue_out[23:16]
  output logic [gmpt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // mask_code[1:0]
  output logic [gmpt_pkg::CODE_W-1:0]         out_tuser,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gmpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gmpt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import gmpt_pkg::*;

  cfg_t cfg;

  gmpt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage enables, ripple from the output side
  logic ld_out, ld5, ld4, ld3, ld2, ld1;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic out_valid_r;

  assign ld_out    = !out_valid_r || out_tready;
  assign ld5       = !v5_r || ld_out;
  assign ld4       = !v4_r || ld5;
  assign ld3       = !v3_r || ld4;
  assign ld2       = !v2_r || ld3;
  assign ld1       = !v1_r || ld2;
  assign in_tready = ld1;

  // stage 1: input register
  mode_t             mode1_r;
  logic [IDX_W-1:0]  col1_r, row1_r;
  logic [RGB_W-1:0]  red1_r, green1_r, blue1_r;
  logic [ADDR_W-1:0] waddr1_r;
  mask_code_t        wcode1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ld1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      mode1_r  <= mode_t'(in_tuser);
      col1_r   <= in_tdata[11:0];
      row1_r   <= in_tdata[23:12];
      red1_r   <= in_tdata[31:24];
      green1_r <= in_tdata[39:32];
      blue1_r  <= in_tdata[47:40];
      waddr1_r <= in_tdata[65:48];
      wcode1_r <= encode_code(in_tdata[73:66]);
    end
  end

  // stage 2: coordinate products and tint value
  mode_t                  mode2_r;
  logic [PROD_W-1:0]      pc2_r, pr2_r;
  logic [RGB_W-1:0]       red2_r, green2_r, blue2_r, tint2_r;
  logic [ADDR_W-1:0]      waddr2_r;
  mask_code_t             wcode2_r;
  logic [SUM_W-1:0]       sum1;
  logic [TINT_PROD_W-1:0] tint_prod1;

  assign sum1 = SUM_W'(red1_r) + SUM_W'(green1_r) + SUM_W'(blue1_r);
  assign tint_prod1 = TINT_PROD_W'(sum1) * TINT_PROD_W'(TINT_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ld2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      mode2_r  <= mode1_r;
      pc2_r    <= PROD_W'(col1_r) * PROD_W'(cfg.col_step);
      pr2_r    <= PROD_W'(row1_r) * PROD_W'(cfg.row_step);
      red2_r   <= red1_r;
      green2_r <= green1_r;
      blue2_r  <= blue1_r;
      tint2_r  <= tint_prod1[TINT_SHIFT+RGB_W-1:TINT_SHIFT];
      waddr2_r <= waddr1_r;
      wcode2_r <= wcode1_r;
    end
  end

  // stage 3: origin add and range check
  mode_t              mode3_r;
  logic               hit3_r;
  logic [MX_W-1:0]    mx3_r;
  logic [MY_W-1:0]    my3_r;
  logic [RGB_W-1:0]   red3_r, green3_r, blue3_r, tint3_r;
  logic [ADDR_W-1:0]  waddr3_r;
  mask_code_t         wcode3_r;
  logic [COORD_W-1:0] ccol2, crow2;
  logic [IP_W-1:0]    ipc2, ipr2;
  logic               in_col2, in_row2;

  assign ccol2 = {{(COORD_W-ORIGIN_W){cfg.col_origin[ORIGIN_W-1]}}, cfg.col_origin}
               + {{(COORD_W-PROD_W){1'b0}}, pc2_r};
  assign crow2 = {{(COORD_W-ORIGIN_W){cfg.row_origin[ORIGIN_W-1]}}, cfg.row_origin}
               + {{(COORD_W-PROD_W){1'b0}}, pr2_r};
  assign ipc2    = ccol2[COORD_W-1:FRAC_BITS];
  assign ipr2    = crow2[COORD_W-1:FRAC_BITS];
  assign in_col2 = !ccol2[COORD_W-1] && (ipc2 < IP_W'(cfg.cols));
  assign in_row2 = !crow2[COORD_W-1] && (ipr2 < IP_W'(cfg.rows));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (ld3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      mode3_r  <= mode2_r;
      hit3_r   <= cfg.active && in_col2 && in_row2;
      mx3_r    <= ipc2[MX_W-1:0];
      my3_r    <= ipr2[MY_W-1:0];
      red3_r   <= red2_r;
      green3_r <= green2_r;
      blue3_r  <= blue2_r;
      tint3_r  <= tint2_r;
      waddr3_r <= waddr2_r;
      wcode3_r <= wcode2_r;
    end
  end

  // stage 4: linear mask address
  mode_t             mode4_r;
  logic              hit4_r;
  logic [ADDR_W-1:0] addr4_r;
  logic [RGB_W-1:0]  red4_r, green4_r, blue4_r, tint4_r;
  mask_code_t        wcode4_r;
  logic [LIN_W-1:0]  lin3;

  assign lin3 = LIN_W'(my3_r) * LIN_W'(cfg.cols) + LIN_W'(mx3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (ld4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      mode4_r  <= mode3_r;
      hit4_r   <= hit3_r && (mode3_r == MODE_PIXEL);
      addr4_r  <= (mode3_r == MODE_PIXEL) ? lin3[ADDR_W-1:0] : waddr3_r;
      red4_r   <= red3_r;
      green4_r <= green3_r;
      blue4_r  <= blue3_r;
      tint4_r  <= tint3_r;
      wcode4_r <= wcode3_r;
    end
  end

  // stage 5: mask store access, loads write and pixels read in arrival order
  mode_t            mode5_r;
  logic             hit5_r;
  logic [RGB_W-1:0] red5_r, green5_r, blue5_r, tint5_r;
  logic [CODE_W-1:0] rd_code;
  logic             mem_en;

  assign mem_en = v4_r && ld5;

  gmpt_mask_ram u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mode4_r == MODE_LOAD),
    .addr  (addr4_r),
    .wdata (wcode4_r),
    .rdata (rd_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (ld5) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      mode5_r  <= mode4_r;
      hit5_r   <= hit4_r;
      red5_r   <= red4_r;
      green5_r <= green4_r;
      blue5_r  <= blue4_r;
      tint5_r  <= tint4_r;
    end
  end

  // output register
  logic [OUT_TDATA_W-1:0] out_data_r;
  mask_code_t             out_code_r;
  logic [OUT_TDATA_W-1:0] px5;
  mask_code_t             code5;

  always_comb begin
    case (hit5_r ? mask_code_t'(rd_code) : CODE_NONE)
      CODE_BLUE: begin
        code5 = CODE_BLUE;
        px5   = {FULL_BYTE, {RGB_W{1'b0}}, {RGB_W{1'b0}}};
      end
      CODE_TINT: begin
        code5 = CODE_TINT;
        px5   = {{RGB_W{1'b0}}, {RGB_W{1'b0}}, tint5_r};
      end
      default: begin
        code5 = CODE_NONE;
        px5   = {blue5_r, green5_r, red5_r};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= v5_r && (mode5_r == MODE_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_data_r <= px5;
      out_code_r <= code5;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_code_r;

  `GMPT_ASSERT_IMPL(a_blue_px, clk, rst_n, out_tvalid && out_tuser == CODE_BLUE, out_tdata[23:16] == FULL_BYTE && out_tdata[15:0] == 16'h0000)
  `GMPT_ASSERT_IMPL(a_tint_px, clk, rst_n, out_tvalid && out_tuser == CODE_TINT, out_tdata[23:8] == 16'h0000)
  `GMPT_ASSERT_IMPL(a_code_legal, clk, rst_n, out_tvalid, out_tuser != 2'd3)
  `GMPT_ASSERT_NEXT(a_rd_hold, clk, rst_n, v5_r && !ld5, $stable(rd_code))
  `GMPT_ASSERT_NEXT(a_load_silent, clk, rst_n, ld_out && v5_r && mode5_r == MODE_LOAD, !out_tvalid)

endmodule
